// ----- rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int unsigned CFG_W         = 25;
    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 25'd16777216;

    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
    localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
    localparam logic [2:0] MASK_LAST_IDX  = 3'd3;

    typedef enum logic [2:0] {
        EV_DATA      = 3'd0,
        EV_EMPTY     = 3'd1,
        EV_PING      = 3'd2,
        EV_CLOSE     = 3'd3,
        EV_TOO_LARGE = 3'd4
    } t_event_kind;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef struct packed {
        logic        valid;
        t_event_kind kind;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        last;
    } t_event;

endpackage

// ----- rtl/wsd_parser.sv -----
`timescale 1ns / 1ps

module wsd_parser
    import wsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat,
    input  logic [7:0]       i_byte,
    input  logic [CFG_W-1:0] i_max_frame_bytes,
    output t_event           o_event
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [63:0] r_len, n_len;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic        r_mask, n_mask;
    logic [3:0]  r_opcode, n_opcode;
    logic [1:0]  r_lane, n_lane;
    logic        r_halted, n_halted;

    logic        is_close, is_ping, is_pong, is_data;
    logic [63:0] len_value;
    logic        len_done, mask_done, too_large;
    logic [63:0] begin_len;
    logic [7:0]  key_byte;

    assign is_close = (r_opcode == OP_CLOSE);
    assign is_ping  = (r_opcode == OP_PING);
    assign is_pong  = (r_opcode == OP_PONG);
    assign is_data  = !(is_close || is_ping || is_pong);

    always_comb begin
        len_value = {r_len[55:0], i_byte};
        len_done  = 1'b0;
        case (r_phase)
            PH_HDR1: begin
                len_done  = (i_byte[6:0] != LEN7_EXT16) && (i_byte[6:0] != LEN7_EXT64);
                // extended forms shift their length in from zero
                len_value = len_done ? {57'd0, i_byte[6:0]} : 64'd0;
            end
            PH_EXT16: len_done = (r_cnt == EXT16_LAST_IDX);
            PH_EXT64: len_done = (r_cnt == EXT64_LAST_IDX);
            default:  len_done = 1'b0;
        endcase
    end

    assign mask_done = (r_phase == PH_MASK) && (r_cnt == MASK_LAST_IDX);
    assign too_large = len_value > {{(64-CFG_W){1'b0}}, i_max_frame_bytes};
    // payload length used when the mask key is absent or complete
    assign begin_len = mask_done ? r_len : len_value;

    always_comb begin
        case (r_lane)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_beat && !r_halted) begin
            case (r_phase)
                PH_HDR0: n_phase = PH_HDR1;
                PH_HDR1, PH_EXT16, PH_EXT64: begin
                    if (r_phase == PH_HDR1 && i_byte[6:0] == LEN7_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (r_phase == PH_HDR1 && i_byte[6:0] == LEN7_EXT64) begin
                        n_phase = PH_EXT64;
                    end else if (len_done) begin
                        if (is_close || (is_data && too_large)) begin
                            n_phase = PH_HDR0;
                        end else if ((r_phase == PH_HDR1) ? i_byte[7] : r_mask) begin
                            n_phase = PH_MASK;
                        end else begin
                            n_phase = (begin_len == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                        end
                    end
                end
                PH_MASK: begin
                    if (mask_done) begin
                        n_phase = (begin_len == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_rem[63:1] == 63'd0) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: n_phase = PH_HDR0;
            endcase
        end
    end

    // datapath and event
    always_comb begin
        logic mask_bit;
        logic go_payload;
        mask_bit   = (r_phase == PH_HDR1) ? i_byte[7] : r_mask;
        go_payload = 1'b0;

        n_cnt    = r_cnt;
        n_len    = r_len;
        n_rem    = r_rem;
        n_key    = r_key;
        n_mask   = r_mask;
        n_opcode = r_opcode;
        n_lane   = r_lane;
        n_halted = r_halted;

        o_event        = '0;
        o_event.kind   = EV_DATA;
        o_event.opcode = r_opcode;

        if (i_beat && !r_halted) begin
            case (r_phase)
                PH_HDR0: n_opcode = i_byte[3:0];
                PH_HDR1, PH_EXT16, PH_EXT64: begin
                    if (r_phase == PH_HDR1) begin
                        n_mask = i_byte[7];
                        n_key  = '0;
                        n_cnt  = '0;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                    n_len = len_value;
                    if (len_done) begin
                        n_cnt = '0;
                        if (is_close) begin
                            n_halted      = 1'b1;
                            o_event.valid = 1'b1;
                            o_event.kind  = EV_CLOSE;
                            o_event.last  = 1'b1;
                        end else if (is_ping) begin
                            o_event.valid = 1'b1;
                            o_event.kind  = EV_PING;
                            o_event.last  = 1'b1;
                            go_payload    = !mask_bit;
                        end else if (is_data && too_large) begin
                            n_halted      = 1'b1;
                            o_event.valid = 1'b1;
                            o_event.kind  = EV_TOO_LARGE;
                            o_event.last  = 1'b1;
                        end else begin
                            go_payload = !mask_bit;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt + 3'd1;
                    if (mask_done) begin
                        n_cnt      = '0;
                        go_payload = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_lane = r_lane + 2'd1;
                    if (r_rem != 64'd0) begin
                        n_rem = r_rem - 64'd1;
                    end
                    if (is_data) begin
                        o_event.valid = 1'b1;
                        o_event.kind  = EV_DATA;
                        o_event.data  = r_mask ? (i_byte ^ key_byte) : i_byte;
                        o_event.last  = (r_rem[63:1] == 63'd0);
                    end
                end
                default: ;
            endcase

            // start the payload, or close out an empty frame
            if (go_payload) begin
                n_lane = '0;
                if (begin_len == 64'd0) begin
                    if (is_data) begin
                        o_event.valid = 1'b1;
                        o_event.kind  = EV_EMPTY;
                        o_event.last  = 1'b1;
                    end
                end else begin
                    n_rem = begin_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_cnt    <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_key    <= '0;
            r_mask   <= 1'b0;
            r_opcode <= '0;
            r_lane   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_mask   <= n_mask;
            r_opcode <= n_opcode;
            r_lane   <= n_lane;
            r_halted <= n_halted;
        end
    end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// Channel   | valid      | stall      | payload
// ----------+------------+------------+-----------------------------------------------
// rx        | i_rx_valid | o_rx_stall | i_rx_byte
// event     | o_ev_valid | i_ev_stall | o_event_kind, o_data_byte, o_frame_opcode,
//           |            |            | o_last_of_frame
// config    | i_cfg_we   | -          | i_cfg_wdata (max_frame_bytes)
//
// One byte is accepted per cycle; each beat is parsed in the cycle it lands and
// its event, if any, appears in the output register on the next cycle.
// The rate is set by the single output register: rx stalls only while an event
// is held there and the event side stalls.
// Synchronous active-low reset returns the parser to the first header byte,
// clears the halt flag and loads the frame limit with its default.
// After a close or oversize event the parser drops every beat until reset.

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_rx_valid,
    output logic             o_rx_stall,
    input  logic [7:0]       i_rx_byte,
    output logic             o_ev_valid,
    input  logic             i_ev_stall,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_frame_opcode,
    output logic             o_last_of_frame
);

    logic [CFG_W-1:0] r_max_frame;
    logic             r_ev_valid;
    t_event           r_ev;
    t_event           parsed;
    logic             rx_beat;

    // hold the input only while a finished event waits on a stalled sink
    assign o_rx_stall = r_ev_valid && i_ev_stall;
    assign rx_beat    = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
        end else if (i_cfg_we) begin
            r_max_frame <= i_cfg_wdata;
        end
    end

    wsd_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_beat            (rx_beat),
        .i_byte            (i_rx_byte),
        .i_max_frame_bytes (r_max_frame),
        .o_event           (parsed)
    );

    // output register: load on every accepted beat, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (rx_beat) begin
            r_ev_valid <= parsed.valid;
        end else if (!i_ev_stall) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_beat && parsed.valid) begin
            r_ev <= parsed;
        end
    end

    assign o_ev_valid      = r_ev_valid;
    assign o_event_kind    = r_ev.kind;
    assign o_data_byte     = r_ev.data;
    assign o_frame_opcode  = r_ev.opcode;
    assign o_last_of_frame = r_ev.last;

endmodule
